>>> rtl/eight_bit_alu_with_flags_macros.svh
// Assertion macros for the eight-bit ALU checker.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define EBALU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define EBALU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ebalu_pkg.sv
// Types and constants shared by the eight-bit ALU modules.
package ebalu_pkg;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBC  = 5'd3,
        OP_AND  = 5'd4,
        OP_XOR  = 5'd5,
        OP_OR   = 5'd6,
        OP_CP   = 5'd7,
        OP_INC  = 5'd8,
        OP_DEC  = 5'd9,
        OP_RLC  = 5'd10,
        OP_RRC  = 5'd11,
        OP_RL   = 5'd12,
        OP_RR   = 5'd13,
        OP_SLA  = 5'd14,
        OP_SRA  = 5'd15,
        OP_SWAP = 5'd16,
        OP_SRL  = 5'd17,
        OP_BIT  = 5'd18,
        OP_RES  = 5'd19,
        OP_SET  = 5'd20,
        OP_DAA  = 5'd21,
        OP_CPL  = 5'd22,
        OP_SCF  = 5'd23,
        OP_CCF  = 5'd24,
        OP_RLCA = 5'd25,
        OP_RRCA = 5'd26,
        OP_RLA  = 5'd27,
        OP_RRA  = 5'd28
    } func_t;

    // Flag bit positions
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
    localparam logic [7:0] DAA_HI_LIM  = 8'h99;
    localparam logic [3:0] DAA_LO_LIM  = 4'h9;

    typedef struct packed {
        logic [7:0] result;
        logic [3:0] flags;
        logic       wr;
    } alu_res_t;

endpackage

>>> rtl/eight_bit_alu_with_flags.sv
// Eight-bit CPU ALU with Z/N/H/C flags: input register, datapath, result register.
//
// Input channel (in_valid/in_ready) carries func, operand_a, operand_b, bit_index
// and flags_in. Output channel (out_valid/out_ready) carries result, flags_out and
// writes_result. A transaction completes when valid and ready are both high.
//
// Structure: one input register, one result register, the whole datapath
// between them; out_valid and the result outputs come from the result
// register.
// Throughput: one operation per cycle while out_ready stays high; every opcode
// takes the same single pass through the datapath.
//
// in_ready is high whenever the input register is empty or can move forward,
// so with out_ready held high a new transaction is taken every cycle.
// When the receiver stalls, the result register holds its transaction, the
// input register fills behind it and then in_ready drops.
//
// Reset (rst_n low, asynchronous) empties both registers; nothing is pending
// after it and in_ready comes up high.
module eight_bit_alu_with_flags
    import ebalu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [4:0] func,
    input  logic [7:0] operand_a,
    input  logic [7:0] operand_b,
    input  logic [2:0] bit_index,
    input  logic [3:0] flags_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] result,
    output logic [3:0] flags_out,
    output logic       writes_result
);

    logic       s1_valid_reg;
    logic [4:0] s1_func_reg;
    logic [7:0] s1_a_reg;
    logic [7:0] s1_b_reg;
    logic [2:0] s1_idx_reg;
    logic [3:0] s1_flags_reg;
    logic       out_valid_reg;
    alu_res_t   out_res_reg;
    alu_res_t   alu_res;
    logic       s2_ready;
    logic       s1_ready;
    logic       in_fire;
    logic       s1_move;

    assign s2_ready = !out_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_fire  = in_valid && s1_ready;
    assign s1_move  = s1_valid_reg && s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_func_reg  <= func;
            s1_a_reg     <= operand_a;
            s1_b_reg     <= operand_b;
            s1_idx_reg   <= bit_index;
            s1_flags_reg <= flags_in;
        end
        if (s1_move)
        begin
            out_res_reg <= alu_res;
        end
    end

    ebalu_core u_core (
        .func      (s1_func_reg),
        .operand_a (s1_a_reg),
        .operand_b (s1_b_reg),
        .bit_index (s1_idx_reg),
        .flags_in  (s1_flags_reg),
        .res       (alu_res)
    );

    assign in_ready      = s1_ready;
    assign out_valid     = out_valid_reg;
    assign result        = out_res_reg.result;
    assign flags_out     = out_res_reg.flags;
    assign writes_result = out_res_reg.wr;

endmodule

>>> rtl/ebalu_core.sv
// Combinational ALU datapath: result byte, flags and write-enable for one operation.
module ebalu_core
    import ebalu_pkg::*;
(
    input  logic [4:0] func,
    input  logic [7:0] operand_a,
    input  logic [7:0] operand_b,
    input  logic [2:0] bit_index,
    input  logic [3:0] flags_in,
    output alu_res_t   res
);

    function automatic logic is_zero(input logic [7:0] v);
        return (v == 8'h00);
    endfunction

    func_t      op;
    logic       cin;
    logic       add_c;
    logic       sub_c;
    logic [8:0] add_sum;
    logic [4:0] add_half;
    logic [8:0] sub_diff;
    logic [4:0] sub_half;
    logic [7:0] sh_src;
    logic [7:0] sh_res;
    logic       sh_co;
    logic [7:0] bit_mask;
    logic [7:0] daa_res;
    logic       daa_co;
    logic [7:0] daa_tmp;

    assign op       = func_t'(func);
    assign cin      = flags_in[FLAG_C];
    assign add_c    = (op == OP_ADC) & cin;
    assign sub_c    = (op == OP_SBC) & cin;
    assign add_sum  = {1'b0, operand_a} + {1'b0, operand_b} + {8'b0, add_c};
    assign add_half = {1'b0, operand_a[3:0]} + {1'b0, operand_b[3:0]} + {4'b0, add_c};
    // Bit 8 / bit 4 of the difference is the borrow out
    assign sub_diff = {1'b0, operand_a} - {1'b0, operand_b} - {8'b0, sub_c};
    assign sub_half = {1'b0, operand_a[3:0]} - {1'b0, operand_b[3:0]} - {4'b0, sub_c};
    assign bit_mask = 8'b0000_0001 << bit_index;

    // Shifter shared by the CB rotates/shifts and the accumulator rotates
    always_comb
    begin
        sh_src = (func inside {OP_RLCA, OP_RRCA, OP_RLA, OP_RRA}) ? operand_a : operand_b;
        case (op)
            OP_RLC, OP_RLCA:
            begin
                sh_co  = sh_src[7];
                sh_res = {sh_src[6:0], sh_src[7]};
            end
            OP_RRC, OP_RRCA:
            begin
                sh_co  = sh_src[0];
                sh_res = {sh_src[0], sh_src[7:1]};
            end
            OP_RL, OP_RLA:
            begin
                sh_co  = sh_src[7];
                sh_res = {sh_src[6:0], cin};
            end
            OP_RR, OP_RRA:
            begin
                sh_co  = sh_src[0];
                sh_res = {cin, sh_src[7:1]};
            end
            OP_SLA:
            begin
                sh_co  = sh_src[7];
                sh_res = {sh_src[6:0], 1'b0};
            end
            OP_SRA:
            begin
                sh_co  = sh_src[0];
                sh_res = {sh_src[7], sh_src[7:1]};
            end
            default:
            begin
                sh_co  = sh_src[0];
                sh_res = {1'b0, sh_src[7:1]};
            end
        endcase
    end

    // Decimal adjust; the low-nibble test sees the value after the high adjust
    always_comb
    begin
        daa_co  = cin;
        daa_tmp = operand_a;
        daa_res = operand_a;
        if (!flags_in[FLAG_N])
        begin
            if (cin || (operand_a > DAA_HI_LIM))
            begin
                daa_tmp = operand_a + DAA_HI_ADJ;
                daa_co  = 1'b1;
            end
            daa_res = daa_tmp;
            if (flags_in[FLAG_H] || (daa_tmp[3:0] > DAA_LO_LIM))
            begin
                daa_res = daa_tmp + DAA_LO_ADJ;
            end
        end
        else
        begin
            if (cin)
            begin
                daa_tmp = operand_a - DAA_HI_ADJ;
            end
            daa_res = daa_tmp;
            if (flags_in[FLAG_H])
            begin
                daa_res = daa_tmp - DAA_LO_ADJ;
            end
        end
    end

    always_comb
    begin
        res.result = operand_a;
        res.flags  = flags_in;
        res.wr     = 1'b1;
        case (op)
            OP_ADD, OP_ADC:
            begin
                res.result = add_sum[7:0];
                res.flags  = {is_zero(add_sum[7:0]), 1'b0, add_half[4], add_sum[8]};
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                res.result = sub_diff[7:0];
                res.flags  = {is_zero(sub_diff[7:0]), 1'b1, sub_half[4], sub_diff[8]};
                res.wr     = (op != OP_CP);
            end
            OP_AND:
            begin
                res.result = operand_a & operand_b;
                res.flags  = {is_zero(operand_a & operand_b), 1'b0, 1'b1, 1'b0};
            end
            OP_XOR:
            begin
                res.result = operand_a ^ operand_b;
                res.flags  = {is_zero(operand_a ^ operand_b), 3'b000};
            end
            OP_OR:
            begin
                res.result = operand_a | operand_b;
                res.flags  = {is_zero(operand_a | operand_b), 3'b000};
            end
            OP_INC:
            begin
                res.result = operand_b + 8'd1;
                res.flags  = {is_zero(operand_b + 8'd1), 1'b0,
                              (operand_b[3:0] == 4'hF), cin};
            end
            OP_DEC:
            begin
                res.result = operand_b - 8'd1;
                res.flags  = {is_zero(operand_b - 8'd1), 1'b1,
                              (operand_b[3:0] == 4'h0), cin};
            end
            OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL:
            begin
                res.result = sh_res;
                res.flags  = {is_zero(sh_res), 2'b00, sh_co};
            end
            OP_RLCA, OP_RRCA, OP_RLA, OP_RRA:
            begin
                res.result = sh_res;
                res.flags  = {3'b000, sh_co};
            end
            OP_SWAP:
            begin
                res.result = {operand_b[3:0], operand_b[7:4]};
                res.flags  = {is_zero(operand_b), 3'b000};
            end
            OP_BIT:
            begin
                res.result = operand_b;
                res.flags  = {is_zero(operand_b & bit_mask), 1'b0, 1'b1, cin};
                res.wr     = 1'b0;
            end
            OP_RES:
            begin
                res.result = operand_b & ~bit_mask;
            end
            OP_SET:
            begin
                res.result = operand_b | bit_mask;
            end
            OP_DAA:
            begin
                res.result = daa_res;
                res.flags  = {is_zero(daa_res), flags_in[FLAG_N], 1'b0, daa_co};
            end
            OP_CPL:
            begin
                res.result = ~operand_a;
                res.flags  = {flags_in[FLAG_Z], 1'b1, 1'b1, cin};
            end
            OP_SCF:
            begin
                res.flags = {flags_in[FLAG_Z], 3'b001};
                res.wr    = 1'b0;
            end
            OP_CCF:
            begin
                res.flags = {flags_in[FLAG_Z], 2'b00, ~cin};
                res.wr    = 1'b0;
            end
            default:
            begin
                // undefined opcodes: pass A and flags through, no write
                res.wr = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/ebalu_checker.sv
// Port-level checker for the eight-bit ALU, bound to the top level.
`include "eight_bit_alu_with_flags_macros.svh"

module ebalu_checker
    import ebalu_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [4:0] func,
    input logic [7:0] operand_a,
    input logic [7:0] operand_b,
    input logic [2:0] bit_index,
    input logic [3:0] flags_in,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] result,
    input logic [3:0] flags_out,
    input logic       writes_result
);

    logic        in_fire;
    logic        out_stall;
    logic [12:0] out_word;

    assign in_fire   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;
    assign out_word  = {result, flags_out, writes_result};

    // A result appearing on an empty output went straight through the input register into the result register
    `EBALU_ASSERT_NOW(a_rise, $rose(out_valid), $past(in_fire, 2), "result without input")

    // A draining output always frees room for a new transaction
    `EBALU_ASSERT_NOW(a_ready_when_drain, out_ready, in_ready, "in_ready low while the output drains")

    // Compare never writes back
    `EBALU_ASSERT_NOW(a_cp_wr, $rose(out_valid) && $past(func, 2) == OP_CP, !writes_result, "cp written")

    // Stalled output holds
    `EBALU_ASSERT_NEXT(a_hold, out_stall, out_valid && $stable(out_word), "stalled output moved")

endmodule

bind eight_bit_alu_with_flags ebalu_checker u_ebalu_checker (.*);
